FILE: hw/rtl/mvc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the mesh vertex compactor.
// No dependencies; used by every module in hw/rtl.
package mvc_pkg;

    localparam int MAX_VERTICES = 65536;
    localparam int TABLE_AW     = 16;
    localparam int TABLE_DEPTH  = 1 << TABLE_AW;
    localparam int CAPACITY     = (MAX_VERTICES < TABLE_DEPTH) ? MAX_VERTICES : TABLE_DEPTH;
    localparam int CNT_W        = TABLE_AW + 1;
    localparam int CFG_AW       = 3;
    localparam int APB_DW       = 32;

    localparam logic [TABLE_AW-1:0] INVALID_IDX = '1;
    localparam logic                CFG_IDX_KEEP_BY_USE = 1'b0;

    typedef logic [TABLE_AW-1:0] t_idx;
    typedef logic [CNT_W-1:0]    t_cnt;

    typedef enum logic [2:0] {
        CMD_START  = 3'd0,
        CMD_MARK   = 3'd1,
        CMD_VERTEX = 3'd2,
        CMD_TRI    = 3'd3,
        CMD_INDEX  = 3'd4
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MARK,
        S_VREAD,
        S_VWRITE,
        S_LOOK,
        S_FIN
    } t_state;

    typedef struct packed {
        t_cmd command;
        t_idx index_a;
        t_idx index_b;
        t_idx index_c;
        logic keep_vertex;
    } t_item;

    typedef struct packed {
        t_cmd kind;
        t_idx new_a;
        t_idx new_b;
        t_idx new_c;
        logic kept;
        logic bad_index;
    } t_result;

    typedef struct packed {
        logic valid;
        t_idx idx;
    } t_entry;

    typedef struct packed {
        logic clear;
        logic rd;
        logic wr;
        t_idx addr;
    } t_mark_req;

    typedef struct packed {
        logic rd;
        logic wr;
        t_idx addr;
        t_entry wdata;
    } t_remap_req;

    typedef struct packed {
        t_entry entry;
        logic   in_range;
    } t_remap_rsp;

endpackage

FILE: hw/rtl/mvc_mark_mem.sv
`timescale 1ns / 1ps
// Used-mark memory, one bit per vertex, with a sweep that clears it after reset and on start.
// Depends on mvc_pkg.
module mvc_mark_mem (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  mvc_pkg::t_mark_req i_req,
    output logic               o_rdata,
    output logic               o_clearing
);

    logic                mem [mvc_pkg::TABLE_DEPTH];
    logic                r_rdata;
    logic                r_clearing;
    mvc_pkg::t_idx       r_clr_cnt;
    logic                w_we;
    logic                w_wdata;
    mvc_pkg::t_idx       w_waddr;

    assign w_we    = r_clearing || i_req.wr;
    assign w_wdata = !r_clearing;
    assign w_waddr = r_clearing ? r_clr_cnt : i_req.addr;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        if (i_req.rd) begin
            r_rdata <= mem[i_req.addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (i_req.clear) begin
            r_clearing <= 1'b1;
            r_clr_cnt  <= '0;
        end else if (r_clearing) begin
            r_clr_cnt <= r_clr_cnt + mvc_pkg::t_idx'(1);
            if (r_clr_cnt == '1) begin
                r_clearing <= 1'b0;
            end
        end
    end

    assign o_rdata    = r_rdata;
    assign o_clearing = r_clearing;

endmodule

FILE: hw/rtl/mvc_remap_unit.sv
`timescale 1ns / 1ps
// Remap table with the shared range compare against the loaded vertex count.
// Depends on mvc_pkg.
module mvc_remap_unit (
    input  logic                i_clk,
    input  mvc_pkg::t_remap_req i_req,
    input  mvc_pkg::t_cnt       i_vtx_cnt,
    output mvc_pkg::t_remap_rsp o_rsp
);

    mvc_pkg::t_entry mem [mvc_pkg::TABLE_DEPTH];
    mvc_pkg::t_entry r_rdata;
    logic            r_in_range;

    always_ff @(posedge i_clk) begin
        if (i_req.wr) begin
            mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.rd) begin
            r_rdata    <= mem[i_req.addr];
            r_in_range <= {1'b0, i_req.addr} < i_vtx_cnt;
        end
    end

    assign o_rsp.entry    = r_rdata;
    assign o_rsp.in_range = r_in_range;

endmodule

FILE: hw/rtl/mesh_vertex_compactor.sv
`timescale 1ns / 1ps
// Top level: command sequencer, counters, APB register and result register.
// States: tri and index S_LOOK, S_FIN; vertex S_VREAD, S_VWRITE; mark_used S_MARK.
// Throughput: one memory access per cycle; the next word is taken when busy falls.
// Start and reset sweep the used marks, holding busy high. Results cannot be stalled.
// Depends on mvc_pkg, mvc_mark_mem, mvc_remap_unit.
module mesh_vertex_compactor (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  mvc_pkg::t_item              i_item,
    output logic                        o_result_valid,
    output mvc_pkg::t_result            o_result,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [mvc_pkg::CFG_AW-1:0]  paddr,
    input  logic [mvc_pkg::APB_DW-1:0]  pwdata,
    output logic [mvc_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    mvc_pkg::t_state     r_state, n_state;
    mvc_pkg::t_item      r_item;
    logic [1:0]          r_slot, n_slot;
    mvc_pkg::t_cnt       r_vtx_cnt, n_vtx_cnt;
    mvc_pkg::t_cnt       r_kept_cnt, n_kept_cnt;
    logic                r_keep_by_use;
    logic                r_rd_vld, n_rd_vld;
    logic [1:0]          r_rd_slot, n_rd_slot;
    mvc_pkg::t_idx       r_new [3];
    mvc_pkg::t_idx       n_new [3];
    logic [2:0]          r_ok, n_ok;
    logic                r_bad, n_bad;
    logic                r_out_vld, n_out_vld;
    mvc_pkg::t_result    r_out, n_out;

    mvc_pkg::t_mark_req  w_mark_req;
    mvc_pkg::t_remap_req w_remap_req;
    mvc_pkg::t_remap_rsp w_remap_rsp;
    logic                w_mark_rdata;
    logic                w_clearing;
    logic                w_accept;
    logic                w_last;
    logic                w_full;
    logic                w_keep;
    logic                w_cfg_wr;
    mvc_pkg::t_idx       w_idx [3];

    mvc_mark_mem u_mark (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_mark_req),
        .o_rdata    (w_mark_rdata),
        .o_clearing (w_clearing)
    );

    mvc_remap_unit u_remap (
        .i_clk     (i_clk),
        .i_req     (w_remap_req),
        .i_vtx_cnt (r_vtx_cnt),
        .o_rsp     (w_remap_rsp)
    );

    assign busy     = (r_state != mvc_pkg::S_IDLE) || w_clearing;
    assign w_accept = start && !busy;
    assign w_idx[0] = r_item.index_a;
    assign w_idx[1] = r_item.index_b;
    assign w_idx[2] = r_item.index_c;
    assign w_last   = (r_item.command == mvc_pkg::CMD_TRI) ? (r_slot == 2'd2) : 1'b1;
    assign w_full   = r_vtx_cnt >= mvc_pkg::t_cnt'(mvc_pkg::CAPACITY);
    assign w_keep   = r_keep_by_use ? w_mark_rdata : r_item.keep_vertex;

    assign w_cfg_wr = psel && penable && pwrite && pready
                      && (paddr[mvc_pkg::CFG_AW-1] == mvc_pkg::CFG_IDX_KEEP_BY_USE);
    assign pready   = 1'b1;
    assign prdata   = (paddr[mvc_pkg::CFG_AW-1] == mvc_pkg::CFG_IDX_KEEP_BY_USE)
                      ? {{(mvc_pkg::APB_DW-1){1'b0}}, r_keep_by_use} : '0;

    always_comb begin
        n_state = r_state;
        case (r_state)
            mvc_pkg::S_IDLE: begin
                if (w_accept) begin
                    case (i_item.command)
                        mvc_pkg::CMD_MARK:   n_state = mvc_pkg::S_MARK;
                        mvc_pkg::CMD_VERTEX: n_state = mvc_pkg::S_VREAD;
                        mvc_pkg::CMD_TRI:    n_state = mvc_pkg::S_LOOK;
                        mvc_pkg::CMD_INDEX:  n_state = mvc_pkg::S_LOOK;
                        default:             n_state = mvc_pkg::S_IDLE;
                    endcase
                end
            end
            mvc_pkg::S_MARK: begin
                if (r_slot == 2'd2) begin
                    n_state = mvc_pkg::S_IDLE;
                end
            end
            mvc_pkg::S_VREAD: begin
                n_state = w_full ? mvc_pkg::S_IDLE : mvc_pkg::S_VWRITE;
            end
            mvc_pkg::S_VWRITE: n_state = mvc_pkg::S_IDLE;
            mvc_pkg::S_LOOK: begin
                if (w_last) begin
                    n_state = mvc_pkg::S_FIN;
                end
            end
            mvc_pkg::S_FIN:    n_state = mvc_pkg::S_IDLE;
            default:           n_state = mvc_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_slot      = r_slot;
        n_vtx_cnt   = r_vtx_cnt;
        n_kept_cnt  = r_kept_cnt;
        n_rd_vld    = 1'b0;
        n_rd_slot   = r_slot;
        n_out_vld   = 1'b0;
        n_out       = r_out;
        n_new       = r_new;
        n_ok        = r_ok;
        n_bad       = r_bad;
        w_mark_req  = '0;
        w_remap_req = '0;

        if (r_rd_vld) begin
            if (!w_remap_rsp.in_range) begin
                n_new[r_rd_slot] = mvc_pkg::INVALID_IDX;
                n_ok[r_rd_slot]  = 1'b0;
                n_bad            = 1'b1;
            end else if (!w_remap_rsp.entry.valid) begin
                n_new[r_rd_slot] = mvc_pkg::INVALID_IDX;
                n_ok[r_rd_slot]  = 1'b0;
            end else begin
                n_new[r_rd_slot] = w_remap_rsp.entry.idx;
            end
        end

        case (r_state)
            mvc_pkg::S_IDLE: begin
                n_slot = 2'd0;
                n_new  = '{default: '0};
                n_ok   = 3'b111;
                n_bad  = 1'b0;
                if (w_accept && (i_item.command == mvc_pkg::CMD_START)) begin
                    w_mark_req.clear = 1'b1;
                    n_vtx_cnt        = '0;
                    n_kept_cnt       = '0;
                end
            end
            mvc_pkg::S_MARK: begin
                w_mark_req.addr = w_idx[r_slot];
                w_mark_req.wr   = {1'b0, w_idx[r_slot]} < mvc_pkg::t_cnt'(mvc_pkg::CAPACITY);
                n_slot          = r_slot + 2'd1;
            end
            mvc_pkg::S_VREAD: begin
                if (w_full) begin
                    n_out_vld = 1'b1;
                    n_out     = '{kind: mvc_pkg::CMD_VERTEX, new_a: mvc_pkg::INVALID_IDX,
                                  new_b: '0, new_c: '0, kept: 1'b0, bad_index: 1'b1};
                end else begin
                    w_mark_req.rd   = 1'b1;
                    w_mark_req.addr = r_vtx_cnt[mvc_pkg::TABLE_AW-1:0];
                end
            end
            mvc_pkg::S_VWRITE: begin
                w_remap_req.wr         = 1'b1;
                w_remap_req.addr       = r_vtx_cnt[mvc_pkg::TABLE_AW-1:0];
                w_remap_req.wdata      = w_keep
                    ? mvc_pkg::t_entry'{valid: 1'b1, idx: r_kept_cnt[mvc_pkg::TABLE_AW-1:0]}
                    : mvc_pkg::t_entry'('0);
                n_vtx_cnt              = r_vtx_cnt + mvc_pkg::t_cnt'(1);
                n_kept_cnt             = r_kept_cnt + mvc_pkg::t_cnt'(w_keep);
                n_out_vld              = 1'b1;
                n_out                  = '{kind: mvc_pkg::CMD_VERTEX,
                    new_a: w_keep ? r_kept_cnt[mvc_pkg::TABLE_AW-1:0] : mvc_pkg::INVALID_IDX,
                    new_b: '0, new_c: '0, kept: w_keep, bad_index: 1'b0};
            end
            mvc_pkg::S_LOOK: begin
                w_remap_req.rd   = 1'b1;
                w_remap_req.addr = w_idx[r_slot];
                n_rd_vld         = 1'b1;
                n_rd_slot        = r_slot;
                n_slot           = r_slot + 2'd1;
            end
            mvc_pkg::S_FIN: begin
                n_out_vld = 1'b1;
                n_out     = '{kind: r_item.command, new_a: n_new[0], new_b: n_new[1],
                              new_c: n_new[2], kept: &n_ok, bad_index: n_bad};
            end
            default: begin
                n_slot = 2'd0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= mvc_pkg::S_IDLE;
            r_slot        <= 2'd0;
            r_vtx_cnt     <= '0;
            r_kept_cnt    <= '0;
            r_keep_by_use <= 1'b0;
            r_rd_vld      <= 1'b0;
            r_out_vld     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_slot     <= n_slot;
            r_vtx_cnt  <= n_vtx_cnt;
            r_kept_cnt <= n_kept_cnt;
            r_rd_vld   <= n_rd_vld;
            r_out_vld  <= n_out_vld;
            if (w_cfg_wr) begin
                r_keep_by_use <= pwdata[0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_item <= i_item;
        end
        r_rd_slot <= n_rd_slot;
        r_new     <= n_new;
        r_ok      <= n_ok;
        r_bad     <= n_bad;
        r_out     <= n_out;
    end

    assign o_result_valid = r_out_vld;
    assign o_result       = r_out;

    a_one_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> !o_result_valid)
        else $error("result strobe held for two cycles");

    a_kept_le_vtx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_kept_cnt <= r_vtx_cnt)
        else $error("kept count exceeds vertex count");

    a_vertex_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && (o_result.kind == mvc_pkg::CMD_VERTEX) && o_result.kept
        |-> r_kept_cnt == ({1'b0, o_result.new_a} + mvc_pkg::t_cnt'(1)))
        else $error("kept vertex index does not match kept count");

    a_bad_not_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid && o_result.bad_index |-> !o_result.kept)
        else $error("out-of-range word reported as kept");

endmodule
